FILE: rtl/schroeder_reverb_defines.svh
// Assertion macros for the Schroeder reverberator.
`ifndef SCHROEDER_REVERB_DEFINES_SVH
`define SCHROEDER_REVERB_DEFINES_SVH
`ifndef SYNTH
// cond holds at an edge, so prop holds at that same edge
`define SRVB_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("srvb: same-cycle check failed");
// cond holds at an edge, so prop holds at the next edge
`define SRVB_ASSERT_NXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("srvb: next-cycle check failed");
`else
`define SRVB_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define SRVB_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: rtl/srvb_pkg.sv
// Constants, register codes and helper functions of the Schroeder reverberator.
package srvb_pkg;

	localparam int COMB_DEPTH    = 4096;
	localparam int ALLPASS_DEPTH = 512;
	localparam int SAMPLE_BITS   = 24;
	localparam int GAIN_BITS     = 15;

	localparam int CB_W  = SAMPLE_BITS + 4;   // comb store word
	localparam int AP_W  = SAMPLE_BITS + 2;   // allpass store word
	localparam int CP_W  = $clog2(COMB_DEPTH);
	localparam int APP_W = $clog2(ALLPASS_DEPTH);
	localparam int CL_W  = 13;
	localparam int AL_W  = 10;
	localparam int CFG_W = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CC_W  = (CL_W > CP_W + 1) ? CL_W : CP_W + 1;
	localparam int AC_W  = (AL_W > APP_W + 1) ? AL_W : APP_W + 1;
	localparam int MUL_W = CB_W + GAIN_BITS + 1;
	localparam int PW    = MUL_W + 1;          // working width, no overflow
	localparam int SUM_W = CB_W + 2;
	localparam int CLR_DEPTH = (COMB_DEPTH > ALLPASS_DEPTH) ? COMB_DEPTH : ALLPASS_DEPTH;
	localparam int CLR_AW    = $clog2(CLR_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_COMB_LENGTH_A    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COMB_LENGTH_B    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COMB_LENGTH_C    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COMB_LENGTH_D    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_LENGTH_A = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_LENGTH_B = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_COMB_FEEDBACK    = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_FEEDBACK = CFG_IDX_W'(7);

	localparam logic [CL_W-1:0]  COMB_LENGTH_A_RST    = CL_W'(2097);
	localparam logic [CL_W-1:0]  COMB_LENGTH_B_RST    = CL_W'(2596);
	localparam logic [CL_W-1:0]  COMB_LENGTH_C_RST    = CL_W'(3076);
	localparam logic [CL_W-1:0]  COMB_LENGTH_D_RST    = CL_W'(3489);
	localparam logic [AL_W-1:0]  ALLPASS_LENGTH_A_RST = AL_W'(427);
	localparam logic [AL_W-1:0]  ALLPASS_LENGTH_B_RST = AL_W'(129);
	localparam logic [CFG_W-1:0] COMB_FEEDBACK_RST    = CFG_W'(25559);
	localparam logic [CFG_W-1:0] ALLPASS_FEEDBACK_RST = CFG_W'(16384);

	typedef logic [CP_W-1:0]  comb_ptr_t;
	typedef logic [APP_W-1:0] ap_ptr_t;

	// clamp to the signed range of bits
	function automatic logic signed [PW-1:0] sat_w(input logic signed [PW-1:0] v,
			input int unsigned bits);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = $signed((PW'(1) << (bits - 1)) - PW'(1));
		lo = -hi - PW'(1);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// next comb position; zero length acts as one, oversize as full depth
	function automatic comb_ptr_t comb_next(input comb_ptr_t p, input logic [CL_W-1:0] len);
		logic [CC_W-1:0] eff;
		logic [CC_W-1:0] np;
		if (len == '0)
			eff = CC_W'(1);
		else if (CC_W'(len) > CC_W'(COMB_DEPTH))
			eff = CC_W'(COMB_DEPTH);
		else
			eff = CC_W'(len);
		np = CC_W'(p) + CC_W'(1);
		if (np >= eff)
			return '0;
		return np[CP_W-1:0];
	endfunction

	function automatic ap_ptr_t ap_next(input ap_ptr_t p, input logic [AL_W-1:0] len);
		logic [AC_W-1:0] eff;
		logic [AC_W-1:0] np;
		if (len == '0)
			eff = AC_W'(1);
		else if (AC_W'(len) > AC_W'(ALLPASS_DEPTH))
			eff = AC_W'(ALLPASS_DEPTH);
		else
			eff = AC_W'(len);
		np = AC_W'(p) + AC_W'(1);
		if (np >= eff)
			return '0;
		return np[APP_W-1:0];
	endfunction

endpackage

FILE: rtl/schroeder_reverb.sv
// Schroeder reverberator: four feedback combs and two allpass sections, one shared multiplier.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  input     | in        | in_valid / in_ready    | sample_in,  24 bit signed Q1.23
//  output    | out       | out_valid / out_ready  | sample_out, 24 bit signed Q1.23
//  config    | in        | cfg_we (no wait)       | cfg_index 3 bit, cfg_data 15 bit
//
//  A request is accepted only in the idle step; the next request is taken in the
//  cycle the result appears, so only one request is in flight at a time. The single
//  multiplier serves the eight gain products (four comb, two per allpass) one after
//  another under the sequencer. After reset a clearing pass zeroes all delay
//  stores over max(COMB_DEPTH, ALLPASS_DEPTH) = 4096 rows, one row per cycle in
//  each bank still within its depth; in_ready stays low meanwhile, configuration
//  writes are taken throughout.
//  A stalled result waits in the sequencer's final step until the output
//  register is free; nothing is dropped.
`include "schroeder_reverb_defines.svh"
module schroeder_reverb import srvb_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	// Sequencer steps. Comb k is multiplied in step Ck and written in C(k+1);
	// each allpass runs multiply, store, multiply, output.
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_C0    = 4'd1;
	localparam logic [ST_W-1:0] ST_C1    = 4'd2;
	localparam logic [ST_W-1:0] ST_C2    = 4'd3;
	localparam logic [ST_W-1:0] ST_C3    = 4'd4;
	localparam logic [ST_W-1:0] ST_C4    = 4'd5;  // write comb 3, first allpass product
	localparam logic [ST_W-1:0] ST_A0S   = 4'd6;
	localparam logic [ST_W-1:0] ST_A0M   = 4'd7;
	localparam logic [ST_W-1:0] ST_A0Y   = 4'd8;
	localparam logic [ST_W-1:0] ST_A1M1  = 4'd9;
	localparam logic [ST_W-1:0] ST_A1S   = 4'd10;
	localparam logic [ST_W-1:0] ST_A1M   = 4'd11;
	localparam logic [ST_W-1:0] ST_A1Y   = 4'd12;
	localparam logic [ST_W-1:0] ST_DONE  = 4'd13;
	localparam logic [ST_W-1:0] ST_CLEAR = 4'd14;

	logic [ST_W-1:0]   state_q;
	logic [CLR_AW-1:0] clr_addr_q;

	// configuration
	logic [CL_W-1:0]  comb_len_q [4];
	logic [AL_W-1:0]  ap_len_q [2];
	logic [CFG_W-1:0] comb_fb_q;
	logic [CFG_W-1:0] ap_fb_q;

	// delay line positions
	comb_ptr_t cptr_q [4];
	ap_ptr_t   aptr_q [2];

	// datapath registers
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [MUL_W-1:0]       prod_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [AP_W-1:0]        y_q;
	logic signed [AP_W-1:0]        s_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          out_valid_q;

	// registered store reads, taken when a request is accepted
	logic signed [CB_W-1:0] crd [4];
	logic signed [AP_W-1:0] ard [2];

	logic in_accept;
	logic out_free;
	logic clearing;
	logic comb_clr;
	logic ap_clr;

	logic signed [CB_W-1:0]      mul_a;
	logic [CFG_W-1:0]            mul_g;
	logic signed [MUL_W-1:0]     mul_p;
	logic signed [PW-1:0]        prod_sh;
	logic signed [PW-1:0]        comb_sat;
	logic signed [PW-1:0]        sum_sat;
	logic signed [PW-1:0]        s_sat;
	logic signed [PW-1:0]        ap_diff;
	logic signed [PW-1:0]        y_sat;
	logic signed [PW-1:0]        o_sat;
	logic signed [AP_W-1:0]      ap_d;
	logic signed [CB_W-1:0]      comb_wd;
	logic signed [AP_W-1:0]      ap_wd;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign clearing = (state_q == ST_CLEAR);
	assign comb_clr = clearing && ({1'b0, clr_addr_q} < (CLR_AW + 1)'(COMB_DEPTH));
	assign ap_clr   = clearing && ({1'b0, clr_addr_q} < (CLR_AW + 1)'(ALLPASS_DEPTH));

	// Shared multiplier: one operand per step, gain chosen by section.
	always_comb begin
		mul_a = '0;
		mul_g = ap_fb_q;
		case (state_q)
			ST_C0: begin
				mul_a = crd[0];
				mul_g = comb_fb_q;
			end
			ST_C1: begin
				mul_a = crd[1];
				mul_g = comb_fb_q;
			end
			ST_C2: begin
				mul_a = crd[2];
				mul_g = comb_fb_q;
			end
			ST_C3: begin
				mul_a = crd[3];
				mul_g = comb_fb_q;
			end
			ST_C4:   mul_a = CB_W'(ard[0]);
			ST_A0M:  mul_a = CB_W'(s_q);
			ST_A1M1: mul_a = CB_W'(ard[1]);
			ST_A1M:  mul_a = CB_W'(s_q);
			default: mul_a = '0;
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, mul_g});

	// Q0.15 product, floor rounding
	assign prod_sh  = PW'(prod_q >>> GAIN_BITS);
	assign comb_sat = sat_w(PW'(x_q) + prod_sh, CB_W);
	assign sum_sat  = sat_w(PW'(sum_q >>> 2), AP_W);
	assign s_sat    = sat_w(PW'(y_q) + prod_sh, AP_W);
	assign ap_d     = (state_q == ST_A0Y) ? ard[0] : ard[1];
	assign ap_diff  = PW'(ap_d) - prod_sh;
	assign y_sat    = sat_w(ap_diff, AP_W);
	// clamping to 26 then 24 bits equals clamping to 24 directly
	assign o_sat    = sat_w(ap_diff, SAMPLE_BITS);

	assign comb_wd = clearing ? '0 : comb_sat[CB_W-1:0];
	assign ap_wd   = clearing ? '0 : s_sat[AP_W-1:0];

	// Comb banks: one write and one read port each.
	for (genvar b = 0; b < 4; b++) begin : g_comb
		logic signed [CB_W-1:0] mem [COMB_DEPTH];
		logic                   we;
		comb_ptr_t              wa;

		assign we = comb_clr || (state_q == ST_W'(ST_C1 + b));
		assign wa = clearing ? clr_addr_q[CP_W-1:0] : cptr_q[b];

		always_ff @(posedge clk) begin
			if (we)
				mem[wa] <= comb_wd;
			if (in_accept)
				crd[b] <= mem[cptr_q[b]];
		end
	end

	// Allpass banks
	for (genvar b = 0; b < 2; b++) begin : g_ap
		logic signed [AP_W-1:0] mem [ALLPASS_DEPTH];
		logic                   we;
		ap_ptr_t                wa;

		assign we = ap_clr || (state_q == ((b == 0) ? ST_A0S : ST_A1S));
		assign wa = clearing ? clr_addr_q[APP_W-1:0] : aptr_q[b];

		always_ff @(posedge clk) begin
			if (we)
				mem[wa] <= ap_wd;
			if (in_accept)
				ard[b] <= mem[aptr_q[b]];
		end
	end

	// Control: sequencer, configuration, pointers, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			comb_len_q[0] <= COMB_LENGTH_A_RST;
			comb_len_q[1] <= COMB_LENGTH_B_RST;
			comb_len_q[2] <= COMB_LENGTH_C_RST;
			comb_len_q[3] <= COMB_LENGTH_D_RST;
			ap_len_q[0]   <= ALLPASS_LENGTH_A_RST;
			ap_len_q[1]   <= ALLPASS_LENGTH_B_RST;
			comb_fb_q     <= COMB_FEEDBACK_RST;
			ap_fb_q       <= ALLPASS_FEEDBACK_RST;
			for (int i = 0; i < 4; i++)
				cptr_q[i] <= '0;
			for (int i = 0; i < 2; i++)
				aptr_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COMB_LENGTH_A:    comb_len_q[0] <= cfg_data[CL_W-1:0];
					REG_COMB_LENGTH_B:    comb_len_q[1] <= cfg_data[CL_W-1:0];
					REG_COMB_LENGTH_C:    comb_len_q[2] <= cfg_data[CL_W-1:0];
					REG_COMB_LENGTH_D:    comb_len_q[3] <= cfg_data[CL_W-1:0];
					REG_ALLPASS_LENGTH_A: ap_len_q[0]   <= cfg_data[AL_W-1:0];
					REG_ALLPASS_LENGTH_B: ap_len_q[1]   <= cfg_data[AL_W-1:0];
					REG_COMB_FEEDBACK:    comb_fb_q     <= cfg_data;
					REG_ALLPASS_FEEDBACK: ap_fb_q       <= cfg_data;
					default: ;
				endcase
			end

			// a new result takes the output register as the old one leaves
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + CLR_AW'(1);
					if (clr_addr_q == CLR_AW'(CLR_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_C0;
				end
				ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_A0S, ST_A0M, ST_A0Y,
				ST_A1M1, ST_A1S, ST_A1M: begin
					state_q <= state_q + ST_W'(1);
				end
				ST_A1Y: begin
					// all stores written: step every line on
					for (int i = 0; i < 4; i++)
						cptr_q[i] <= comb_next(cptr_q[i], comb_len_q[i]);
					for (int i = 0; i < 2; i++)
						aptr_q[i] <= ap_next(aptr_q[i], ap_len_q[i]);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_accept)
			x_q <= sample_in;
		case (state_q)
			ST_C0:   sum_q <= SUM_W'(crd[0]);
			ST_C1:   sum_q <= sum_q + SUM_W'(crd[1]);
			ST_C2:   sum_q <= sum_q + SUM_W'(crd[2]);
			ST_C3:   sum_q <= sum_q + SUM_W'(crd[3]);
			ST_C4:   y_q   <= sum_sat[AP_W-1:0];
			ST_A0S:  s_q   <= s_sat[AP_W-1:0];
			ST_A0Y:  y_q   <= y_sat[AP_W-1:0];
			ST_A1S:  s_q   <= s_sat[AP_W-1:0];
			ST_A1Y:  res_q <= o_sat[SAMPLE_BITS-1:0];
			ST_DONE: begin
				if (out_free)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

	`SRVB_ASSERT_NXT(a_accept_starts_seq, clk, arst_n, in_valid && in_ready, state_q == ST_C0)
	`SRVB_ASSERT_IMP(a_result_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_DONE)
	`SRVB_ASSERT_IMP(a_no_result_in_clear, clk, arst_n, state_q == ST_CLEAR, !out_valid_q)

endmodule

FILE: bench/schroeder_reverb_test.sv
// Self-checking bench for the Schroeder reverberator: random requests against a bit-true predictor.
module schroeder_reverb_test import srvb_pkg::*; ();

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [CFG_W-1:0] GAIN_MAX = {CFG_W{1'b1}};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]              cfg_data = '0;

	schroeder_reverb u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the delay lines, pointers and registers (stores start cleared)
	bit signed [CB_W-1:0] comb_mem [4][COMB_DEPTH];
	bit signed [AP_W-1:0] ap_mem [2][ALLPASS_DEPTH];
	int unsigned comb_pos [4];
	int unsigned ap_pos [2];
	int unsigned comb_len [4] = '{COMB_LENGTH_A_RST, COMB_LENGTH_B_RST,
		COMB_LENGTH_C_RST, COMB_LENGTH_D_RST};
	int unsigned ap_len [2] = '{ALLPASS_LENGTH_A_RST, ALLPASS_LENGTH_B_RST};
	int unsigned comb_fb = COMB_FEEDBACK_RST;
	int unsigned ap_fb = ALLPASS_FEEDBACK_RST;

	logic signed [SAMPLE_BITS-1:0] pending_samples [$];   // requests not yet offered
	logic signed [SAMPLE_BITS-1:0] wet_expected [$];      // predicted results, oldest first
	logic signed [SAMPLE_BITS-1:0] want;
	logic [CFG_W-1:0] setting [8];

	bit in_taken = 1'b0;
	bit in_busy = 1'b0;
	bit out_taken = 1'b0;
	bit calm = 1'b0;      // no idling on either side while set
	int in_gap = 0;
	int out_hold = 0;
	int fault_count = 0;
	int accepted_count = 0;
	int result_count = 0;
	int setting_count = 0;

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// effective delay: zero acts as one, oversize as the full store
	function automatic int unsigned span(input int unsigned len, input int unsigned depth);
		if (len == 0)
			return 1;
		if (len > depth)
			return depth;
		return len;
	endfunction

	// one dry sample through four combs, the quarter-scaled sum, then two allpass sections
	function automatic logic signed [SAMPLE_BITS-1:0] reverb_predict(
			input logic signed [SAMPLE_BITS-1:0] dry);
		longint x, d, s, y, sum;
		int unsigned len, p;
		int c;
		x = dry;
		sum = 0;
		for (c = 0; c < 4; c++) begin
			len = span(comb_len[c], COMB_DEPTH);
			p = comb_pos[c];
			d = comb_mem[c][p];
			comb_mem[c][p] = CB_W'(clamp(x + ((d * longint'(comb_fb)) >>> GAIN_BITS), CB_W));
			comb_pos[c] = (p + 1 >= len) ? 0 : p + 1;
			sum += d;
		end
		y = clamp(sum >>> 2, AP_W);
		for (c = 0; c < 2; c++) begin
			len = span(ap_len[c], ALLPASS_DEPTH);
			p = ap_pos[c];
			d = ap_mem[c][p];
			s = clamp(y + ((d * longint'(ap_fb)) >>> GAIN_BITS), AP_W);
			ap_mem[c][p] = AP_W'(s);
			y = clamp(d - ((s * longint'(ap_fb)) >>> GAIN_BITS), AP_W);
			ap_pos[c] = (p + 1 >= len) ? 0 : p + 1;
		end
		return SAMPLE_BITS'(clamp(y, SAMPLE_BITS));
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	// Sampling at the rising edge: request acceptance feeds the predictor,
	// result acceptance is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			wet_expected.push_back(reverb_predict(sample_in));
			accepted_count++;
			in_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			out_taken = 1'b1;
			if (wet_expected.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result %0d arrived with none expected: got %0d",
						result_count, sample_out);
			end else begin
				want = wet_expected.pop_front();
				if (sample_out !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result %0d mismatch: expected %0d, got %0d",
							result_count, want, sample_out);
				end
			end
		end
	end

	// Request driver: one gap per request; valid is held until the handshake.
	always @(negedge clk) begin
		if (in_taken) begin
			in_taken = 1'b0;
			in_busy = 1'b0;
			in_gap = calm ? 0 : $urandom_range(0, 10);
		end
		if (!in_busy) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample_in <= pending_samples.pop_front();
				in_valid <= 1'b1;
				in_busy = 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// Result side: a stall drawn after every accepted result
	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 1'b0;
			out_hold = calm ? 0 : $urandom_range(0, 10);
		end
		if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// Sender stops until every prediction is matched, then a short idle margin
	task automatic wait_drained();
		while (pending_samples.size() != 0 || in_busy || wet_expected.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Write all eight registers from setting[], mirroring each into the predictor
	task automatic program_reverb();
		int i;
		logic [CFG_IDX_W-1:0] idx;
		for (i = 0; i < 8; i++) begin
			idx = CFG_IDX_W'(i);
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= setting[i];
			case (idx)
				REG_COMB_LENGTH_A:    comb_len[0] = setting[i][CL_W-1:0];
				REG_COMB_LENGTH_B:    comb_len[1] = setting[i][CL_W-1:0];
				REG_COMB_LENGTH_C:    comb_len[2] = setting[i][CL_W-1:0];
				REG_COMB_LENGTH_D:    comb_len[3] = setting[i][CL_W-1:0];
				REG_ALLPASS_LENGTH_A: ap_len[0] = setting[i][AL_W-1:0];
				REG_ALLPASS_LENGTH_B: ap_len[1] = setting[i][AL_W-1:0];
				REG_COMB_FEEDBACK:    comb_fb = setting[i];
				REG_ALLPASS_FEEDBACK: ap_fb = setting[i];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	// mostly short lines so feedback shows up within a phase
	function automatic logic [CFG_W-1:0] pick_length(input int depth, input int field_max);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'(depth);
			2: return CFG_W'($urandom_range(depth + 1, field_max));
			3: return CFG_W'($urandom);
			4: return CFG_W'($urandom_range(1, depth));
			default: return CFG_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_MAX;
			2: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(16384, 32767));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0, 1, 2: return SAMPLE_BITS'($urandom);
			3, 4: return SAMPLE_BITS'($urandom_range(0, 8191)) - SAMPLE_BITS'(4096);
			5: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			6: return '0;
			default: return $urandom_range(0, 1) ? SAMPLE_BITS'(1) : -SAMPLE_BITS'(1);
		endcase
	endfunction

	initial begin
		int ph, k;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: extremes of the sample; pointers move while the
		// combs still read the cleared stores.
		pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, '0, SAMPLE_BITS'(1), -SAMPLE_BITS'(1),
			SAMPLE_BITS'(24'h555555), SAMPLE_BITS'(24'hAAAAAA)};
		wait_drained();

		// Zero and oversize lengths, full gains, then runs of the sample extremes.
		// The shrink also catches pointers already past the new lengths.
		setting[0] = '0;
		setting[1] = CFG_W'(1);
		setting[2] = CFG_W'(8191);
		setting[3] = CFG_W'(COMB_DEPTH);
		setting[4] = '0;
		setting[5] = CFG_W'(1023);
		setting[6] = GAIN_MAX;
		setting[7] = GAIN_MAX;
		program_reverb();
		for (k = 0; k < 8; k++)
			pending_samples.push_back(SAMPLE_MAX);
		for (k = 0; k < 8; k++)
			pending_samples.push_back(SAMPLE_MIN);
		wait_drained();

		// Random phases, each under a fresh setting; every fourth with no idling
		for (ph = 0; ph < 14; ph++) begin
			calm = (ph % 4 == 3);
			for (k = 0; k < 4; k++)
				setting[k] = pick_length(COMB_DEPTH, 8191);
			for (k = 4; k < 6; k++)
				setting[k] = pick_length(ALLPASS_DEPTH, 1023);
			setting[6] = pick_gain();
			setting[7] = pick_gain();
			program_reverb();
			for (k = 0; k < 100; k++)
				pending_samples.push_back(pick_sample());
			wait_drained();
		end

		if (wet_expected.size() != 0) begin
			fault_count++;
			$display("%0d predicted results never arrived", wet_expected.size());
		end
		$display("covered %0d requests and %0d results over %0d register settings,",
			accepted_count, result_count, setting_count + 1);
		$display("zero, full and oversize lengths and gains, saturating inputs, random idling");
		if (fault_count == 0)
			$display("schroeder_reverb_test OK");
		else
			$display("schroeder_reverb_test NOT OK");
		$finish;
	end

	// Watchdog: well beyond the slowest legal run including the clearing pass
	initial begin
		#4000000;
		$display("timeout: %0d predictions outstanding", wet_expected.size());
		$display("schroeder_reverb_test NOT OK");
		$finish;
	end

endmodule

FILE: schroeder_reverb.f
+incdir+rtl
rtl/srvb_pkg.sv
rtl/schroeder_reverb.sv
bench/schroeder_reverb_test.sv
